FILE: design/hcd_pkg.sv
// Shared types, codes and helpers for the chunked transfer decoder.
// No dependencies; used by hcd_step and http_chunked_decoder.
package hcd_pkg;

	localparam int SIZE_BITS_DEF = 32;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE    = 3'd0,
		PH_SIZE_LF = 3'd1,
		PH_DATA    = 3'd2,
		PH_DATA_CR = 3'd3,
		PH_DATA_LF = 3'd4,
		PH_END_CR  = 3'd5,
		PH_END_LF  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_DONE     = 3'd1,
		ST_BADSIZE  = 3'd2,
		ST_BADTERM  = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		phase_t  phase;
		logic    digit_seen;
		status_t status;
	} ctrl_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_t;

	localparam ctrl_t CTRL_RESET = '{phase: PH_SIZE, digit_seen: 1'b0, status: ST_BUSY};

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

FILE: design/hcd_step.sv
// Per-byte decode step: next framing state and result for one body byte.
// Depends on hcd_pkg.
module hcd_step
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic [7:0]           data_byte,
	input  logic                 body_start,
	input  ctrl_t                cur_ctrl,
	input  logic [SIZE_BITS-1:0] cur_remaining,
	output ctrl_t                nxt_ctrl,
	output logic [SIZE_BITS-1:0] nxt_remaining,
	output logic                 is_payload,
	output logic [7:0]           payload_byte
);

	ctrl_t                ctrl;
	logic [SIZE_BITS-1:0] rem;
	logic [SIZE_BITS-1:0] rem_dec;
	hex_t                 hex;

	always_comb begin
		// body_start clears the decoder before this byte is taken
		ctrl = body_start ? CTRL_RESET : cur_ctrl;
		rem = body_start ? '0 : cur_remaining;
		rem_dec = rem - SIZE_BITS'(1);
		hex = hex_digit(data_byte);
	end

	always_comb begin
		nxt_ctrl = ctrl;
		nxt_remaining = rem;
		is_payload = 1'b0;
		if (ctrl.status == ST_BUSY) begin
			unique case (ctrl.phase)
				PH_SIZE: begin
					if (hex.ok) begin
						if (rem[SIZE_BITS-1 -: 4] != 4'd0) begin
							nxt_ctrl.status = ST_OVERFLOW;
						end else begin
							nxt_remaining = {rem[SIZE_BITS-5:0], hex.value};
							nxt_ctrl.digit_seen = 1'b1;
						end
					end else if (data_byte == CH_CR && ctrl.digit_seen) begin
						nxt_ctrl.phase = PH_SIZE_LF;
					end else begin
						nxt_ctrl.status = ST_BADSIZE;
					end
				end
				PH_SIZE_LF: begin
					if (data_byte != CH_LF) begin
						nxt_ctrl.status = ST_BADSIZE;
					end else if (rem == '0) begin
						nxt_ctrl.phase = PH_END_CR;
					end else begin
						nxt_ctrl.phase = PH_DATA;
					end
				end
				PH_DATA: begin
					is_payload = 1'b1;
					nxt_remaining = rem_dec;
					if (rem_dec == '0) begin
						nxt_ctrl.phase = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (data_byte == CH_CR) begin
						nxt_ctrl.phase = PH_DATA_LF;
					end else begin
						nxt_ctrl.status = ST_BADTERM;
					end
				end
				PH_DATA_LF: begin
					if (data_byte == CH_LF) begin
						nxt_ctrl.phase = PH_SIZE;
						nxt_ctrl.digit_seen = 1'b0;
						nxt_remaining = '0;
					end else begin
						nxt_ctrl.status = ST_BADTERM;
					end
				end
				PH_END_CR: begin
					if (data_byte == CH_CR) begin
						nxt_ctrl.phase = PH_END_LF;
					end
				end
				PH_END_LF: begin
					// a repeated CR keeps waiting for LF
					if (data_byte == CH_LF) begin
						nxt_ctrl.status = ST_DONE;
					end else if (data_byte != CH_CR) begin
						nxt_ctrl.phase = PH_END_CR;
					end
				end
				default: begin
					nxt_ctrl.phase = PH_SIZE;
				end
			endcase
		end
		payload_byte = is_payload ? data_byte : 8'd0;
	end

endmodule

FILE: design/http_chunked_decoder.sv
// HTTP chunked transfer decoder, top level: input register, decode step, result register.
// Depends on hcd_pkg and hcd_step.
//
// Takes the message body one byte per transaction and gives one result per byte:
// the byte itself with is_payload set when it is chunk data, else zeros, plus a
// status (busy, complete, bad size line, bad chunk terminator, size overflow) that
// holds once it leaves busy until a byte arrives with body_start set. One byte is
// accepted per clock cycle unless a staged byte waits on a full result register
// with out_ready low. The input register loads when a byte is accepted and the
// result register when that byte advances, so a stalled output holds one byte in
// each register. Every byte updates the framing state registers as it advances. The
// chunk size register is SIZE_BITS wide; larger sizes report overflow.
module http_chunked_decoder
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       body_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       is_payload,
	output logic [2:0] status
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 start_s1;
	logic                 advance;

	ctrl_t                ctrl_q;
	logic [SIZE_BITS-1:0] remaining_q;
	ctrl_t                ctrl_nxt;
	logic [SIZE_BITS-1:0] remaining_nxt;
	logic                 is_payload_nxt;
	logic [7:0]           payload_nxt;

	logic                 out_valid_q;
	logic [7:0]           payload_q;
	logic                 is_payload_q;
	status_t              status_q;

	// move the staged byte on when the result register is free or draining
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			start_s1 <= body_start;
		end
	end

	hcd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.data_byte    (data_s1),
		.body_start   (start_s1),
		.cur_ctrl     (ctrl_q),
		.cur_remaining(remaining_q),
		.nxt_ctrl     (ctrl_nxt),
		.nxt_remaining(remaining_nxt),
		.is_payload   (is_payload_nxt),
		.payload_byte (payload_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= CTRL_RESET;
			remaining_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				ctrl_q <= ctrl_nxt;
				remaining_q <= remaining_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			payload_q <= payload_nxt;
			is_payload_q <= is_payload_nxt;
			status_q <= ctrl_nxt.status;
		end
	end

	assign out_valid = out_valid_q;
	assign payload_byte = payload_q;
	assign is_payload = is_payload_q;
	assign status = 3'(status_q);

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for http_chunked_decoder: chunked bodies in, decoded bytes out.
// Depends on hcd_pkg (phase and status codes, CR/LF constants) and the decoder RTL.
module testbench;
	import hcd_pkg::*;

	localparam int SIZE_W = SIZE_BITS_DEF;
	localparam int QUIET_LIMIT = 4000;
	localparam int TARGET_BYTES = 950;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} body_byte_t;

	typedef struct {
		logic [7:0] payload_byte;
		logic       is_payload;
		status_t    status;
	} decoded_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       body_start = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] payload_byte;
	logic       is_payload;
	logic [2:0] status;

	body_byte_t body_q[$];
	decoded_t   decoded_q[$];
	int         total_bytes = 0;
	int         bytes_sent = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	logic       in_taken = 1'b0;
	logic       noisy = 1'b0;

	// decoder state as the testbench sees it
	phase_t            dec_phase = PH_SIZE;
	logic [SIZE_W-1:0] dec_left = '0;
	logic              dec_digit = 1'b0;
	status_t           dec_status = ST_BUSY;

	http_chunked_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.body_start(body_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.is_payload(is_payload),
		.status(status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic decode_byte(input logic [7:0] c, input logic start, output decoded_t res);
		logic       hex_ok;
		logic [3:0] hex_val;
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			hex_val = c[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
		if (start) begin
			dec_phase = PH_SIZE;
			dec_left = '0;
			dec_digit = 1'b0;
			dec_status = ST_BUSY;
		end
		res.payload_byte = 8'h00;
		res.is_payload = 1'b0;
		if (dec_status == ST_BUSY) begin
			case (dec_phase)
				PH_SIZE: begin
					if (hex_ok) begin
						// flag rather than shift digits out of the top
						if (dec_left[SIZE_W-1 -: 4] != 4'd0) begin
							dec_status = ST_OVERFLOW;
						end else begin
							dec_left = {dec_left[SIZE_W-5:0], hex_val};
							dec_digit = 1'b1;
						end
					end else if (c == CH_CR && dec_digit) begin
						dec_phase = PH_SIZE_LF;
					end else begin
						dec_status = ST_BADSIZE;
					end
				end
				PH_SIZE_LF: begin
					if (c != CH_LF) begin
						dec_status = ST_BADSIZE;
					end else if (dec_left == '0) begin
						dec_phase = PH_END_CR;
					end else begin
						dec_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					res.payload_byte = c;
					res.is_payload = 1'b1;
					dec_left = dec_left - 1'b1;
					if (dec_left == '0) begin
						dec_phase = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (c == CH_CR) begin
						dec_phase = PH_DATA_LF;
					end else begin
						dec_status = ST_BADTERM;
					end
				end
				PH_DATA_LF: begin
					if (c == CH_LF) begin
						dec_phase = PH_SIZE;
						dec_left = '0;
						dec_digit = 1'b0;
					end else begin
						dec_status = ST_BADTERM;
					end
				end
				PH_END_CR: begin
					if (c == CH_CR) begin
						dec_phase = PH_END_LF;
					end
				end
				PH_END_LF: begin
					if (c == CH_LF) begin
						dec_status = ST_DONE;
					end else if (c != CH_CR) begin
						dec_phase = PH_END_CR;
					end
				end
				default: begin
					dec_phase = PH_SIZE;
				end
			endcase
		end
		res.status = dec_status;
	endtask

	// corrupt framing now and then while a broken body is being built
	task automatic put(input logic [7:0] c, input logic start);
		body_byte_t b;
		b.data = c;
		b.start = start;
		if (noisy && $urandom_range(0, 29) == 0) begin
			b.data = 8'($urandom_range(0, 255));
		end
		if (noisy && $urandom_range(0, 59) == 0) begin
			b.start = 1'b1;
		end
		body_q.push_back(b);
	endtask

	// octal escapes: \015 is CR, \200 is 0x80
	task automatic put_text(input string s, input logic start);
		for (int i = 0; i < s.len(); i++) begin
			put(s[i], start && i == 0);
		end
	endtask

	function automatic logic [7:0] hex_char(input int unsigned v);
		if (v < 10) begin
			return 8'(8'h30 + v);
		end
		return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
	endfunction

	task automatic put_size(input int unsigned n, input logic start);
		logic [3:0]  nib[8];
		int          k;
		int unsigned v;
		logic        first;
		k = 0;
		v = n;
		first = start;
		do begin
			nib[k] = v[3:0];
			v = v >> 4;
			k++;
		end while (v != 0);
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
			put(8'h30, first);
			first = 1'b0;
		end
		for (int i = k - 1; i >= 0; i--) begin
			put(hex_char(nib[i]), first);
			first = 1'b0;
		end
		put(CH_CR, 1'b0);
		put(CH_LF, 1'b0);
	endtask

	task automatic gen_body();
		int          kind;
		int unsigned len;
		logic        first;
		kind = $urandom_range(0, 99);
		noisy = ($urandom_range(0, 99) < 20);
		first = 1'b1;
		if (kind < 5) begin
			// oversized chunk size line
			put(hex_char($urandom_range(1, 15)), 1'b1);
			repeat ($urandom_range(8, 10)) put(hex_char($urandom_range(0, 15)), 1'b0);
			repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)), 1'b0);
		end else if (kind < 10) begin
			put(8'($urandom_range(0, 255)), 1'b1);
			repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			repeat ($urandom_range(0, 4)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
				put_size(len, first);
				first = 1'b0;
				repeat (len) put(8'($urandom_range(0, 255)), 1'b0);
				put(CH_CR, 1'b0);
				put(CH_LF, 1'b0);
			end
			put_size(0, first);
			repeat ($urandom_range(0, 3)) begin
				put($urandom_range(0, 3) == 0 ? CH_CR : 8'($urandom_range(0, 255)), 1'b0);
			end
			put(CH_CR, 1'b0);
			put(CH_LF, 1'b0);
			repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)), 1'b0);
		end
		noisy = 1'b0;
	endtask

	function automatic idle_mode_t idle_mode();
		case ((bytes_sent * 4) / (total_bytes > 0 ? total_bytes : 1))
			0: return IDLE_NONE;
			1: return IDLE_SEND;
			2: return IDLE_RECV;
			default: return IDLE_BOTH;
		endcase
	endfunction

	// sender: advance to the next byte once the current one is taken
	always @(negedge clk) begin
		body_byte_t b;
		int         pct;
		case (idle_mode())
			IDLE_SEND: pct = 87;
			IDLE_BOTH: pct = 12;
			default:   pct = 0;
		endcase
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (body_q.size() > 0 && $urandom_range(0, 99) >= pct) begin
				b = body_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= b.data;
				body_start <= b.start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		int pct;
		case (idle_mode())
			IDLE_RECV: pct = 87;
			IDLE_BOTH: pct = 12;
			default:   pct = 0;
		endcase
		out_ready <= arst_n && ($urandom_range(0, 99) >= pct);
	end

	always @(posedge clk) begin
		decoded_t want;
		decoded_t res;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$error("result with no byte outstanding: payload_byte %h status %0d",
						payload_byte, status);
					mismatches++;
				end else begin
					want = decoded_q.pop_front();
					if (payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %h, got %h", want.payload_byte, payload_byte);
						mismatches++;
					end
					if (is_payload !== want.is_payload) begin
						$error("is_payload: expected %b, got %b", want.is_payload, is_payload);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(data_byte, body_start, res);
				decoded_q.push_back(res);
				bytes_sent++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// good body: leading zero, extreme bytes, junk and CR CR LF after the last chunk
		put_text("02\015\n", 1'b1);
		put(8'h00, 1'b0);
		put(8'hFF, 1'b0);
		put_text("\015\n0\015\nx\015\015\n", 1'b0);
		// empty size line, then a byte under held status
		put_text("\015B", 1'b1);
		// non-hex character on the size line
		put_text("g", 1'b1);
		// CR without LF on the size line
		put_text("F\015x", 1'b1);
		// data not followed by CR
		put_text("1\015\n\200x", 1'b1);
		// size past the register width
		put_text("1aF000000", 1'b1);
		while (body_q.size() < TARGET_BYTES) begin
			gen_body();
		end
		total_bytes = body_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < total_bytes) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
design/hcd_pkg.sv
design/hcd_step.sv
design/http_chunked_decoder.sv
dv/testbench.sv
